// ----- rtl/wmf_pkg.sv -----
package wmf_pkg;

    localparam int MAX_LINE   = 1024;
    localparam int ADDR_BITS  = $clog2(MAX_LINE);
    localparam int PIXEL_BITS = 16;
    localparam int LEN_BITS   = 11;
    localparam int LINES_BITS = 21;
    localparam int WGT_BITS   = 8;
    localparam int POS_BITS   = 31;
    localparam int MAX_LINES  = 1048576;

    // divisor is weight plus up to eight neighbors
    localparam int CNT_BITS   = WGT_BITS + 1;
    // magnitude of the weighted sum is at most (255 + 8) * 2^(PIXEL_BITS-1)
    localparam int DIV_BITS   = PIXEL_BITS + CNT_BITS - 1;
    localparam int STEP_BITS  = $clog2(DIV_BITS + 1);
    localparam int CHK_BITS   = 64;

    localparam logic [1:0] REG_LINE_LENGTH   = 2'd0;
    localparam logic [1:0] REG_LINE_COUNT    = 2'd1;
    localparam logic [1:0] REG_CENTRE_WEIGHT = 2'd2;

    typedef struct packed {
        logic                      start;
        logic [DIV_BITS-1:0]       dividend;
        logic [CNT_BITS-1:0]       divisor;
    } div_req_t;

    typedef struct packed {
        logic                      done;
        logic [DIV_BITS-1:0]       quotient;
    } div_rsp_t;

endpackage

// ----- rtl/weighted_3x3_mean_filter_top.sv -----
// Edge-normalized weighted 3x3 mean filter. Pixels stream in raster order; each
// output is the centre times centre_weight plus the neighbors inside the frame,
// divided by centre_weight plus the neighbor count, truncated toward zero, with a
// running 64-bit checksum of the frame's outputs and frame_last on the final one.
// Outputs trail inputs by line_length+1 pixels; after the last pixel send
// line_length+1 flush requests (cmd=1, or further pixels) to drain the frame.
// Registers are sampled by the first pixel of a frame. An ignored request stays
// in idle; others pass through shift and, when they produce an output, through
// sum, add, the bit-serial divider (24 steps) and output, held by out_stall.
// The two line delays live in one 1024x32 single-port memory, written back once
// per request that is not ignored; it needs no clearing after reset.
module weighted_3x3_mean_filter_top
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [3:0]                            paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  cmd,
    input  logic signed [wmf_pkg::PIXEL_BITS-1:0] pixel_in,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [wmf_pkg::PIXEL_BITS-1:0] pixel_out,
    output logic                                  frame_last,
    output logic signed [wmf_pkg::CHK_BITS-1:0]   frame_checksum
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SHIFT = 3'd1;
    localparam logic [2:0] S_SUM   = 3'd2;
    localparam logic [2:0] S_ADD   = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    localparam int PB = wmf_pkg::PIXEL_BITS;
    localparam int PROD_BITS = PB + wmf_pkg::WGT_BITS + 1;
    localparam int NSUM_BITS = PB + 3;
    localparam int SUM_BITS  = PROD_BITS + 1;

    // configuration
    logic [wmf_pkg::LEN_BITS-1:0]   cfg_len_reg;
    logic [wmf_pkg::LINES_BITS-1:0] cfg_lines_reg;
    logic [wmf_pkg::WGT_BITS-1:0]   cfg_wgt_reg;
    logic                           cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_len_reg   <= wmf_pkg::LEN_BITS'(1024);
            cfg_lines_reg <= wmf_pkg::LINES_BITS'(1024);
            cfg_wgt_reg   <= wmf_pkg::WGT_BITS'(2);
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                wmf_pkg::REG_LINE_LENGTH:   cfg_len_reg   <= pwdata[wmf_pkg::LEN_BITS-1:0];
                wmf_pkg::REG_LINE_COUNT:    cfg_lines_reg <= pwdata[wmf_pkg::LINES_BITS-1:0];
                wmf_pkg::REG_CENTRE_WEIGHT: cfg_wgt_reg   <= pwdata[wmf_pkg::WGT_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            wmf_pkg::REG_LINE_LENGTH:   prdata = 32'(cfg_len_reg);
            wmf_pkg::REG_LINE_COUNT:    prdata = 32'(cfg_lines_reg);
            wmf_pkg::REG_CENTRE_WEIGHT: prdata = 32'(cfg_wgt_reg);
            default:                    prdata = '0;
        endcase
    end

    // frame state
    logic [2:0]                        state_reg, state_next;
    logic [wmf_pkg::LEN_BITS-1:0]      len_reg, len_next;
    logic [wmf_pkg::LINES_BITS-1:0]    lines_reg, lines_next;
    logic [wmf_pkg::WGT_BITS-1:0]      wgt_reg, wgt_next;
    logic [wmf_pkg::POS_BITS-1:0]      total_reg, total_next;
    logic [wmf_pkg::POS_BITS-1:0]      pos_reg, pos_next;
    logic [wmf_pkg::ADDR_BITS-1:0]     ring_reg, ring_next;
    logic [wmf_pkg::LEN_BITS-1:0]      col_reg, col_next;
    logic [wmf_pkg::LINES_BITS-1:0]    row_reg, row_next;
    logic [wmf_pkg::CHK_BITS-1:0]      acc_reg, acc_next;
    logic                              emit_reg, emit_next;
    logic                              out_valid_reg, out_valid_next;

    // datapath
    logic signed [PB-1:0]              win_reg [9];
    logic signed [PB-1:0]              pix_reg;
    logic signed [PROD_BITS-1:0]       prod_reg;
    logic signed [NSUM_BITS-1:0]       nsum_reg;
    logic [wmf_pkg::CNT_BITS-1:0]      cnt_reg;
    logic                              neg_reg;
    logic signed [PB-1:0]              pix_out_reg;
    logic                              last_out_reg;
    logic [wmf_pkg::CHK_BITS-1:0]      chk_out_reg;

    logic [2*PB-1:0]                   mem_rd;
    wmf_pkg::div_req_t                 div_req;
    wmf_pkg::div_rsp_t                 div_rsp;

    logic                              accept, first, drop, out_free;
    logic                              up, dn, lf, rt, last;
    logic [wmf_pkg::LEN_BITS-1:0]      lat_len;
    logic [wmf_pkg::LINES_BITS-1:0]    lat_lines;
    logic signed [NSUM_BITS-1:0]       nsum;
    logic [wmf_pkg::CNT_BITS-1:0]      cnt;
    logic signed [SUM_BITS-1:0]        sum;
    logic [SUM_BITS-1:0]               sum_abs;
    logic signed [wmf_pkg::DIV_BITS:0] res;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign first    = (pos_reg == '0);
    assign drop     = cmd && (first || (pos_reg < total_reg));
    assign out_free = !out_valid_reg || !out_stall;

    assign lat_len   = (cfg_len_reg == '0) ? wmf_pkg::LEN_BITS'(1)
                     : (cfg_len_reg > wmf_pkg::LEN_BITS'(wmf_pkg::MAX_LINE))
                       ? wmf_pkg::LEN_BITS'(wmf_pkg::MAX_LINE) : cfg_len_reg;
    assign lat_lines = (cfg_lines_reg == '0) ? wmf_pkg::LINES_BITS'(1)
                     : (cfg_lines_reg > wmf_pkg::LINES_BITS'(wmf_pkg::MAX_LINES))
                       ? wmf_pkg::LINES_BITS'(wmf_pkg::MAX_LINES) : cfg_lines_reg;

    assign up   = (row_reg != '0);
    assign dn   = ({1'b0, row_reg} + 1'b1) < {1'b0, lines_reg};
    assign lf   = (col_reg != '0);
    assign rt   = ({1'b0, col_reg} + 1'b1) < {1'b0, len_reg};
    assign last = !dn && !rt;

    // neighbor sum with edge masking
    always_comb
    begin
        logic signed [NSUM_BITS-1:0] a0, a1, a2, a3, a5, a6, a7, a8;
        a0 = (up && lf) ? NSUM_BITS'(win_reg[0]) : '0;
        a1 = up         ? NSUM_BITS'(win_reg[1]) : '0;
        a2 = (up && rt) ? NSUM_BITS'(win_reg[2]) : '0;
        a3 = lf         ? NSUM_BITS'(win_reg[3]) : '0;
        a5 = rt         ? NSUM_BITS'(win_reg[5]) : '0;
        a6 = (dn && lf) ? NSUM_BITS'(win_reg[6]) : '0;
        a7 = dn         ? NSUM_BITS'(win_reg[7]) : '0;
        a8 = (dn && rt) ? NSUM_BITS'(win_reg[8]) : '0;
        nsum = ((a0 + a1) + (a2 + a3)) + ((a5 + a6) + (a7 + a8));
        cnt  = wmf_pkg::CNT_BITS'(wgt_reg)
             + wmf_pkg::CNT_BITS'(up && lf) + wmf_pkg::CNT_BITS'(up)
             + wmf_pkg::CNT_BITS'(up && rt) + wmf_pkg::CNT_BITS'(lf)
             + wmf_pkg::CNT_BITS'(rt) + wmf_pkg::CNT_BITS'(dn && lf)
             + wmf_pkg::CNT_BITS'(dn) + wmf_pkg::CNT_BITS'(dn && rt);
    end

    assign sum     = SUM_BITS'(prod_reg) + SUM_BITS'(nsum_reg);
    assign sum_abs = sum[SUM_BITS-1] ? SUM_BITS'(-sum) : SUM_BITS'(sum);
    assign res     = neg_reg ? -$signed({1'b0, div_rsp.quotient})
                             : $signed({1'b0, div_rsp.quotient});

    assign div_req.start    = (state_reg == S_ADD);
    assign div_req.dividend = sum_abs[wmf_pkg::DIV_BITS-1:0];
    assign div_req.divisor  = cnt_reg;

    always_comb
    begin
        logic [wmf_pkg::CHK_BITS-1:0] chk;
        chk            = acc_reg + wmf_pkg::CHK_BITS'(res);
        state_next     = state_reg;
        len_next       = len_reg;
        lines_next     = lines_reg;
        wgt_next       = wgt_reg;
        total_next     = total_reg;
        pos_next       = pos_reg;
        ring_next      = ring_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        acc_next       = acc_reg;
        emit_next      = emit_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && !drop)
                begin
                    if (first)
                    begin
                        len_next   = lat_len;
                        lines_next = lat_lines;
                        wgt_next   = (cfg_wgt_reg == '0) ? wmf_pkg::WGT_BITS'(1)
                                                         : cfg_wgt_reg;
                    end
                    emit_next  = !first
                               && (pos_reg > wmf_pkg::POS_BITS'(len_reg));
                    pos_next   = pos_reg + 1'b1;
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                total_next = wmf_pkg::POS_BITS'(len_reg) * wmf_pkg::POS_BITS'(lines_reg);
                if ((wmf_pkg::LEN_BITS'(ring_reg) + 1'b1) >= len_reg)
                begin
                    ring_next = '0;
                end
                else
                begin
                    ring_next = ring_reg + 1'b1;
                end
                state_next = emit_reg ? S_SUM : S_IDLE;
            end
            S_SUM:   state_next = S_ADD;
            S_ADD:   state_next = S_DIV;
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    if (last)
                    begin
                        pos_next  = '0;
                        ring_next = '0;
                        acc_next  = '0;
                        col_next  = '0;
                        row_next  = '0;
                    end
                    else
                    begin
                        acc_next = chk;
                        if (rt)
                        begin
                            col_next = col_reg + 1'b1;
                        end
                        else
                        begin
                            col_next = '0;
                            row_next = row_reg + 1'b1;
                        end
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= wmf_pkg::LEN_BITS'(1024);
            lines_reg     <= wmf_pkg::LINES_BITS'(1024);
            wgt_reg       <= wmf_pkg::WGT_BITS'(2);
            total_reg     <= '0;
            pos_reg       <= '0;
            ring_reg      <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            acc_reg       <= '0;
            emit_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < 9; k++)
            begin
                win_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            lines_reg     <= lines_next;
            wgt_reg       <= wgt_next;
            total_reg     <= total_next;
            pos_reg       <= pos_next;
            ring_reg      <= ring_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            acc_reg       <= acc_next;
            emit_reg      <= emit_next;
            out_valid_reg <= out_valid_next;
            if (state_reg == S_SHIFT)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    win_reg[k*3]   <= win_reg[k*3+1];
                    win_reg[k*3+1] <= win_reg[k*3+2];
                end
                win_reg[2] <= $signed(mem_rd[2*PB-1:PB]);
                win_reg[5] <= $signed(mem_rd[PB-1:0]);
                win_reg[8] <= pix_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !drop)
        begin
            // pixels past the frame's end only drain the window
            pix_reg <= (!first && (pos_reg >= total_reg)) ? '0 : pixel_in;
        end
        if (state_reg == S_SUM)
        begin
            prod_reg <= $signed({1'b0, wgt_reg}) * win_reg[4];
            nsum_reg <= nsum;
            cnt_reg  <= cnt;
        end
        if (state_reg == S_ADD)
        begin
            neg_reg <= sum[SUM_BITS-1];
        end
        if (state_reg == S_OUT && out_free)
        begin
            pix_out_reg  <= res[PB-1:0];
            last_out_reg <= last;
            chk_out_reg  <= acc_reg + wmf_pkg::CHK_BITS'(res);
        end
    end

    wmf_linemem u_linemem
    (
        .clk     (clk),
        .addr    (ring_reg),
        .wr_en   (state_reg == S_SHIFT),
        .wr_data ({mem_rd[PB-1:0], pix_reg}),
        .rd_data (mem_rd)
    );

    wmf_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign out_valid      = out_valid_reg;
    assign pixel_out      = pix_out_reg;
    assign frame_last     = last_out_reg;
    assign frame_checksum = $signed(chk_out_reg);

endmodule

// ----- rtl/wmf_linemem.sv -----
module wmf_linemem
(
    input  logic                                 clk,
    input  logic [wmf_pkg::ADDR_BITS-1:0]        addr,
    input  logic                                 wr_en,
    input  logic [2*wmf_pkg::PIXEL_BITS-1:0]     wr_data,
    output logic [2*wmf_pkg::PIXEL_BITS-1:0]     rd_data
);

    // upper half holds the line two back, lower half the line one back
    logic [2*wmf_pkg::PIXEL_BITS-1:0] mem [wmf_pkg::MAX_LINE];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
        rd_data <= mem[addr];
    end

endmodule

// ----- rtl/wmf_div.sv -----
module wmf_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  wmf_pkg::div_req_t req,
    output wmf_pkg::div_rsp_t rsp
);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [wmf_pkg::STEP_BITS-1:0]     step_reg, step_next;
    logic [wmf_pkg::DIV_BITS-1:0]      quo_reg, quo_next;
    logic [wmf_pkg::CNT_BITS:0]        rem_reg, rem_next;
    logic [wmf_pkg::CNT_BITS-1:0]      dvs_reg, dvs_next;
    logic [wmf_pkg::CNT_BITS:0]        rem_sh;
    logic                              ge;

    assign rem_sh = {rem_reg[wmf_pkg::CNT_BITS-1:0], quo_reg[wmf_pkg::DIV_BITS-1]};
    assign ge     = rem_sh >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = wmf_pkg::STEP_BITS'(wmf_pkg::DIV_BITS);
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            // restoring division, one quotient bit per cycle
            rem_next  = ge ? rem_sh - {1'b0, dvs_reg} : rem_sh;
            quo_next  = {quo_reg[wmf_pkg::DIV_BITS-2:0], ge};
            step_next = step_reg - 1'b1;
            if (step_reg == wmf_pkg::STEP_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ----- rtl/wmf_checker.sv -----
module wmf_checker
(
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  psel,
    input logic                                  penable,
    input logic                                  pwrite,
    input logic [3:0]                            paddr,
    input logic [31:0]                           pwdata,
    input logic [31:0]                           prdata,
    input logic                                  pready,
    input logic                                  in_valid,
    input logic                                  in_stall,
    input logic                                  cmd,
    input logic signed [wmf_pkg::PIXEL_BITS-1:0] pixel_in,
    input logic                                  out_valid,
    input logic                                  out_stall,
    input logic signed [wmf_pkg::PIXEL_BITS-1:0] pixel_out,
    input logic                                  frame_last,
    input logic signed [wmf_pkg::CHK_BITS-1:0]   frame_checksum
);

    logic                                 new_frame_reg;
    logic [wmf_pkg::CHK_BITS-1:0]         prev_chk_reg;
    logic                                 out_acc;
    logic [wmf_pkg::CHK_BITS-1:0]         expect_chk;

    assign out_acc    = out_valid && !out_stall;
    assign expect_chk = (new_frame_reg ? '0 : prev_chk_reg)
                      + wmf_pkg::CHK_BITS'(pixel_out);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            new_frame_reg <= 1'b1;
            prev_chk_reg  <= '0;
        end
        else if (out_acc)
        begin
            new_frame_reg <= frame_last;
            prev_chk_reg  <= frame_checksum;
        end
    end

    // stalled result request holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pixel_out)
                                   && $stable(frame_last) && $stable(frame_checksum))
        else $error("stalled output changed");

    // checksum chains over the frame's outputs
    a_chk_chain: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc |-> (frame_checksum == $signed(expect_chk)))
        else $error("checksum does not follow outputs");

    // weight register reads back what was written
    a_wgt_read: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready && (paddr == 4'd8)
        |=> (paddr != 4'd8) || (prdata[7:0] == $past(pwdata[7:0])))
        else $error("weight register readback mismatch");

endmodule

bind weighted_3x3_mean_filter_top wmf_checker u_wmf_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .cmd            (cmd),
    .pixel_in       (pixel_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .pixel_out      (pixel_out),
    .frame_last     (frame_last),
    .frame_checksum (frame_checksum)
);

// ----- verif/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam bit CMD_PIXEL = 1'b0;
    localparam bit CMD_FLUSH = 1'b1;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE_CYCLES = 60;

    typedef struct {
        bit                                     cmd;
        logic signed [wmf_pkg::PIXEL_BITS-1:0]  pix;
    } request_t;

    typedef struct {
        logic signed [wmf_pkg::PIXEL_BITS-1:0]  pixel;
        logic                                   last;
        logic [wmf_pkg::CHK_BITS-1:0]           checksum;
    } filtered_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_stall;
    logic cmd = 1'b0;
    logic signed [wmf_pkg::PIXEL_BITS-1:0] pixel_in = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [wmf_pkg::PIXEL_BITS-1:0] pixel_out;
    logic frame_last;
    logic signed [wmf_pkg::CHK_BITS-1:0] frame_checksum;

    weighted_3x3_mean_filter_top uut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd), .pixel_in(pixel_in),
        .out_valid(out_valid), .out_stall(out_stall), .pixel_out(pixel_out),
        .frame_last(frame_last), .frame_checksum(frame_checksum)
    );

    request_t  pending_q[$];
    filtered_t expected_q[$];
    bit failed = 1'b0;
    int cycles = 0;
    int items_sent = 0;

    // register copies and filter state
    int unsigned reg_len = 1024, reg_lines = 1024, reg_wgt = 2;
    int unsigned frm_len = 1024, frm_lines = 1024, frm_wgt = 2;
    logic signed [wmf_pkg::PIXEL_BITS-1:0] older_line[wmf_pkg::MAX_LINE];
    logic signed [wmf_pkg::PIXEL_BITS-1:0] newer_line[wmf_pkg::MAX_LINE];
    logic signed [wmf_pkg::PIXEL_BITS-1:0] win[9];
    int unsigned in_pos = 0, out_pos = 0, col = 0;
    logic [wmf_pkg::CHK_BITS-1:0] chk_sum = '0;

    bit in_taken = 1'b0;
    request_t cur_req;
    int in_gap = 0, out_gap = 0;
    bit in_idling = 1'b0, out_idling = 1'b0;

    initial
    begin
        foreach (older_line[i])
        begin
            older_line[i] = '0;
            newer_line[i] = '0;
        end
        foreach (win[i])
            win[i] = '0;
    end

    initial
    begin
        forever #4 clk = ~clk;
    end

    task automatic latch_frame();
        frm_len = (reg_len == 0) ? 1 : reg_len;
        if (frm_len > wmf_pkg::MAX_LINE)
            frm_len = wmf_pkg::MAX_LINE;
        frm_lines = (reg_lines == 0) ? 1 : reg_lines;
        if (frm_lines > wmf_pkg::MAX_LINES)
            frm_lines = wmf_pkg::MAX_LINES;
        frm_wgt = (reg_wgt == 0) ? 1 : reg_wgt;
    endtask

    task automatic filter_step(bit c, logic signed [wmf_pkg::PIXEL_BITS-1:0] px);
        int unsigned total, p, r, cl, cnt;
        longint acc, res;
        bit up, dn, lf, rt;
        logic signed [wmf_pkg::PIXEL_BITS-1:0] v;
        filtered_t e;
        v = px;
        if (in_pos == 0)
        begin
            if (c == CMD_FLUSH)
                return;
            latch_frame();
            col = 0;
            out_pos = 0;
            chk_sum = '0;
        end
        total = frm_len * frm_lines;
        if (in_pos < total && c == CMD_FLUSH)
            return;
        if (in_pos >= total)
            v = '0;
        for (int k = 0; k < 3; k++)
        begin
            win[k*3] = win[k*3+1];
            win[k*3+1] = win[k*3+2];
        end
        if (col >= wmf_pkg::MAX_LINE)
            col = 0;
        win[2] = older_line[col];
        win[5] = newer_line[col];
        win[8] = v;
        older_line[col] = newer_line[col];
        newer_line[col] = v;
        col++;
        if (col >= frm_len)
            col = 0;
        p = in_pos;
        in_pos++;
        if (p < frm_len + 1)
            return;
        p = out_pos;
        r = p / frm_len;
        cl = p % frm_len;
        up = r > 0;
        dn = r + 1 < frm_lines;
        lf = cl > 0;
        rt = cl + 1 < frm_len;
        acc = longint'(frm_wgt) * longint'(win[4]);
        cnt = frm_wgt;
        if (lf) begin acc += win[3]; cnt++; end
        if (rt) begin acc += win[5]; cnt++; end
        if (up)
        begin
            acc += win[1]; cnt++;
            if (lf) begin acc += win[0]; cnt++; end
            if (rt) begin acc += win[2]; cnt++; end
        end
        if (dn)
        begin
            acc += win[7]; cnt++;
            if (lf) begin acc += win[6]; cnt++; end
            if (rt) begin acc += win[8]; cnt++; end
        end
        res = acc / longint'(cnt);
        chk_sum = chk_sum + res;
        out_pos++;
        e.pixel = res[wmf_pkg::PIXEL_BITS-1:0];
        e.checksum = chk_sum;
        e.last = 1'b0;
        if (p + 1 >= total)
        begin
            e.last = 1'b1;
            in_pos = 0;
            out_pos = 0;
            chk_sum = '0;
            col = 0;
        end
        expected_q.push_back(e);
    endtask

    // acceptance, prediction and checking
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
        else if (rst_n)
        begin
            in_taken <= in_valid && !in_stall;
            if (in_valid && !in_stall)
                filter_step(cur_req.cmd, cur_req.pix);
            if (out_valid && !out_stall)
            begin
                out_gap = out_idling ? $urandom_range(0, 12) : 0;
                if ($urandom_range(0, 60) == 0)
                    out_idling = !out_idling;
                if (expected_q.size() == 0)
                begin
                    $error("output with nothing expected: pixel_out=%0d", pixel_out);
                    failed = 1'b1;
                end
                else
                begin
                    filtered_t e;
                    e = expected_q.pop_front();
                    if (pixel_out !== e.pixel)
                    begin
                        $error("pixel_out expected %0d got %0d", e.pixel, pixel_out);
                        failed = 1'b1;
                    end
                    if (frame_last !== e.last)
                    begin
                        $error("frame_last expected %0d got %0d", e.last, frame_last);
                        failed = 1'b1;
                    end
                    if (frame_checksum !== e.checksum)
                    begin
                        $error("frame_checksum expected %0d got %0d",
                               $signed(e.checksum), frame_checksum);
                        failed = 1'b1;
                    end
                end
            end
        end
    end

    // request driver
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!(in_valid && !in_taken))
        begin
            if (in_gap > 0)
            begin
                in_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_q.size() > 0)
            begin
                cur_req = pending_q.pop_front();
                cmd <= cur_req.cmd;
                pixel_in <= cur_req.pix;
                in_valid <= 1'b1;
                in_gap = in_idling ? $urandom_range(0, 12) : 0;
                if ($urandom_range(0, 60) == 0)
                    in_idling = !in_idling;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // output back-pressure
    always @(negedge clk)
    begin
        if (out_gap > 0)
        begin
            out_gap--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    function automatic logic signed [wmf_pkg::PIXEL_BITS-1:0] pick_pixel();
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return '0;
            3: return -16'sd1;
            default: return wmf_pkg::PIXEL_BITS'($urandom);
        endcase
    endfunction

    task automatic push_req(bit c, logic signed [wmf_pkg::PIXEL_BITS-1:0] px);
        request_t q;
        q.cmd = c;
        q.pix = px;
        pending_q.push_back(q);
        items_sent++;
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (idx)
            wmf_pkg::REG_LINE_LENGTH: reg_len = val & 32'h7ff;
            wmf_pkg::REG_LINE_COUNT: reg_lines = val & 32'h1fffff;
            default: reg_wgt = val & 32'hff;
        endcase
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic configure(int unsigned len, int unsigned lines, int unsigned wgt);
        write_reg(wmf_pkg::REG_LINE_LENGTH, len);
        write_reg(wmf_pkg::REG_LINE_COUNT, lines);
        write_reg(wmf_pkg::REG_CENTRE_WEIGHT, wgt);
    endtask

    // one frame with its drain; noise adds ignored flushes
    task automatic send_frame(bit noise);
        int unsigned fl, fn, npx;
        fl = (reg_len == 0) ? 1
           : (reg_len > wmf_pkg::MAX_LINE ? wmf_pkg::MAX_LINE : reg_len);
        fn = (reg_lines == 0) ? 1 : reg_lines;
        npx = fl * fn;
        if (noise && $urandom_range(0, 1))
            push_req(CMD_FLUSH, pick_pixel());
        for (int unsigned i = 0; i < npx; i++)
        begin
            push_req(CMD_PIXEL, pick_pixel());
            if (noise && $urandom_range(0, 7) == 0)
                push_req(CMD_FLUSH, pick_pixel());
        end
        // drain: flush requests and surplus pixels both count
        for (int unsigned i = 0; i < fl + 1; i++)
            push_req($urandom_range(0, 2) ? CMD_FLUSH : CMD_PIXEL, pick_pixel());
    endtask

    task automatic wait_idle();
        while (pending_q.size() > 0 || in_valid || expected_q.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes of weight and pixel values, clamped registers
        configure(3, 3, 255);
        push_req(CMD_FLUSH, 16'sh7fff);
        for (int i = 0; i < 9; i++)
            push_req(CMD_PIXEL, (i % 2) ? 16'sh7fff : 16'sh8000);
        for (int i = 0; i < 4; i++)
            push_req(CMD_FLUSH, '0);
        wait_idle();
        configure(0, 0, 0);
        push_req(CMD_PIXEL, 16'sh8000);
        push_req(CMD_PIXEL, 16'sh7fff);
        push_req(CMD_FLUSH, '0);
        wait_idle();
        configure(2, 2, 1);
        for (int i = 0; i < 4; i++)
            push_req(CMD_PIXEL, 16'sh7fff);
        push_req(CMD_FLUSH, '0);
        push_req(CMD_FLUSH, '0);
        push_req(CMD_PIXEL, 16'sh1234);
        wait_idle();
        // largest line count, then an out-of-range line count and its masking
        write_reg(wmf_pkg::REG_LINE_COUNT, 1048576);
        write_reg(wmf_pkg::REG_LINE_COUNT, 32'hffffffff);

        // random phases, mostly small frames
        while (items_sent < 800)
        begin
            configure($urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 8),
                      $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 6),
                      $urandom_range(0, 255));
            repeat ($urandom_range(1, 4))
                send_frame(1'b1);
            wait_idle();
        end

        if (!failed)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
